// ===== rtl/rpn_pkg.sv =====
package rpn_pkg;

    // Fixed field widths.
    localparam int DATA_W  = 32;
    localparam int TOKEN_W = 8;
    localparam int ERR_W   = 3;

    // Default stack depth handed to the top level.
    localparam int DEF_STACK_DEPTH = 16;

    // ASCII codes of the recognized characters.
    localparam logic [TOKEN_W-1:0] TOK_ZERO  = 8'h30;
    localparam logic [TOKEN_W-1:0] TOK_NINE  = 8'h39;
    localparam logic [TOKEN_W-1:0] TOK_PLUS  = 8'h2B;
    localparam logic [TOKEN_W-1:0] TOK_MINUS = 8'h2D;
    localparam logic [TOKEN_W-1:0] TOK_STAR  = 8'h2A;
    localparam logic [TOKEN_W-1:0] TOK_SLASH = 8'h2F;

    // Error codes reported with each result.
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_UNDERFLOW = 3'd1,
        ERR_DIVZERO   = 3'd2,
        ERR_OVERFLOW  = 3'd3,
        ERR_LEFTOVER  = 3'd4
    } err_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_DIV,
        ST_WB,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic push;
        logic flag_en;
        err_t flag_code;
        logic rd_issue;
        logic alu_load;
        logic div_start;
        logic div_load;
        logic pop;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic is_div;
        logic err_set;
        logic full;
        logic lt2;
        logic newer_zero;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/rpn_div.sv =====
module rpn_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [rpn_pkg::DATA_W-1:0]  dividend,
    input  logic signed [rpn_pkg::DATA_W-1:0]  divisor,
    output logic                               done,
    output logic signed [rpn_pkg::DATA_W-1:0]  quotient
);

    localparam int W     = rpn_pkg::DATA_W;
    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     quo_next;
    logic [W-1:0]     den_reg;
    logic [W-1:0]     den_next;
    logic             neg_reg;
    logic             neg_next;

    logic [W:0]       shifted;
    logic [W:0]       trial;
    logic [W-1:0]     dividend_mag;
    logic [W-1:0]     divisor_mag;

    // Magnitudes of the operands; the most negative value maps to 2^(W-1).
    assign dividend_mag = dividend[W-1] ? (~dividend + W'(1)) : dividend;
    assign divisor_mag  = divisor[W-1]  ? (~divisor + W'(1))  : divisor;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend_mag;
            den_next  = divisor_mag;
            neg_next  = dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control flops.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // Apply the sign; a magnitude of 2^(W-1) with a positive sign wraps.
    assign done     = done_reg;
    assign quotient = neg_reg ? signed'(~quo_reg + W'(1)) : signed'(quo_reg);

endmodule

// ===== rtl/rpn_dp.sv =====
module rpn_dp
#(
    parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  rpn_pkg::cmd_t                      cmd,
    output rpn_pkg::sts_t                      sts,
    input  logic [rpn_pkg::TOKEN_W-1:0]        token,
    input  logic                               end_of_expr,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [rpn_pkg::DATA_W-1:0]  top_value,
    output logic [rpn_pkg::ERR_W-1:0]          error_code,
    output logic                               last
);

    localparam int W      = rpn_pkg::DATA_W;
    localparam int TW     = rpn_pkg::TOKEN_W;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // The top of stack lives in top_reg; deeper entries live in the memory.
    logic [W-1:0]       mem [STACK_DEPTH];
    logic [W-1:0]       rd_data_reg;
    logic [W-1:0]       top_reg;
    logic [W-1:0]       res_reg;
    logic [TW-1:0]      token_reg;
    logic               end_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    rpn_pkg::err_t      err_reg;
    rpn_pkg::err_t      err_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [W-1:0]       out_top_reg;
    rpn_pkg::err_t      out_err_reg;
    logic               out_last_reg;

    logic [CNT_W-1:0]   count_m1;
    logic [CNT_W-1:0]   count_m2;
    logic               is_digit;
    logic               is_op;
    logic [W-1:0]       digit_value;
    logic [W-1:0]       alu_result;
    logic               div_done;
    logic signed [W-1:0] div_quotient;
    rpn_pkg::err_t      err_final;
    logic [W-1:0]       top_shown;

    assign count_m1 = count_reg - CNT_W'(1);
    assign count_m2 = count_reg - CNT_W'(2);

    // Token classification.
    assign is_digit = (token_reg >= rpn_pkg::TOK_ZERO) && (token_reg <= rpn_pkg::TOK_NINE);
    assign is_op    = (token_reg == rpn_pkg::TOK_PLUS) || (token_reg == rpn_pkg::TOK_MINUS)
                   || (token_reg == rpn_pkg::TOK_STAR) || (token_reg == rpn_pkg::TOK_SLASH);
    assign digit_value = {{(W - TW){1'b0}}, token_reg - rpn_pkg::TOK_ZERO};

    // Add, subtract and multiply on older (memory) and newer (top) operands.
    always_comb
    begin
        priority case (1'b1)
            (token_reg == rpn_pkg::TOK_PLUS):  alu_result = rd_data_reg + top_reg;
            (token_reg == rpn_pkg::TOK_MINUS): alu_result = rd_data_reg - top_reg;
            default:                           alu_result = rd_data_reg * top_reg;
        endcase
    end

    rpn_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (signed'(rd_data_reg)),
        .divisor  (signed'(top_reg)),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Status back to the controller.
    always_comb
    begin
        sts.is_digit   = is_digit;
        sts.is_op      = is_op;
        sts.is_div     = (token_reg == rpn_pkg::TOK_SLASH);
        sts.err_set    = (err_reg != rpn_pkg::ERR_NONE);
        sts.full       = (count_reg >= CNT_W'(STACK_DEPTH));
        sts.lt2        = (count_reg < CNT_W'(2));
        sts.newer_zero = (top_reg == '0);
        sts.div_done   = div_done;
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    // Final error of this item, with the leftover check at the end of an expression.
    assign err_final = (end_reg && (err_reg == rpn_pkg::ERR_NONE) && (count_reg != CNT_W'(1)))
                     ? rpn_pkg::ERR_LEFTOVER : err_reg;
    assign top_shown = (count_reg == '0) ? '0 : top_reg;

    // Stack count and sticky error.
    always_comb
    begin
        count_next = count_reg;
        err_next   = err_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.pop)
        begin
            count_next = count_m1;
        end
        if (cmd.flag_en)
        begin
            err_next = cmd.flag_code;
        end
        if (cmd.emit && end_reg)
        begin
            count_next = '0;
            err_next   = rpn_pkg::ERR_NONE;
        end
    end

    // Output register valid: set on a new result, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            err_reg       <= rpn_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.push && (count_reg != '0))
        begin
            mem[count_m1[ADDR_W-1:0]] <= top_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[count_m2[ADDR_W-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            token_reg <= token;
            end_reg   <= end_of_expr;
        end
        if (cmd.push)
        begin
            top_reg <= digit_value;
        end
        else if (cmd.pop)
        begin
            top_reg <= res_reg;
        end
        if (cmd.alu_load)
        begin
            res_reg <= alu_result;
        end
        else if (cmd.div_load)
        begin
            res_reg <= div_quotient;
        end
        if (cmd.emit)
        begin
            out_top_reg  <= top_shown;
            out_err_reg  <= err_final;
            out_last_reg <= end_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign top_value  = signed'(out_top_reg);
    assign error_code = out_err_reg;
    assign last       = out_last_reg;

endmodule

// ===== rtl/rpn_ctrl.sv =====
module rpn_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  rpn_pkg::sts_t sts,
    output rpn_pkg::cmd_t cmd
);

    rpn_pkg::state_t state_reg;
    rpn_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpn_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpn_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rpn_pkg::ST_DECODE;
                end
            end
            rpn_pkg::ST_DECODE:
            begin
                if (!sts.err_set && sts.is_op && !sts.lt2 && !(sts.is_div && sts.newer_zero))
                begin
                    state_next = rpn_pkg::ST_READ;
                end
                else
                begin
                    state_next = rpn_pkg::ST_FINISH;
                end
            end
            rpn_pkg::ST_READ:
            begin
                state_next = sts.is_div ? rpn_pkg::ST_DIV : rpn_pkg::ST_WB;
            end
            rpn_pkg::ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = rpn_pkg::ST_WB;
                end
            end
            rpn_pkg::ST_WB:
            begin
                state_next = rpn_pkg::ST_FINISH;
            end
            rpn_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = rpn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rpn_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd           = '0;
        cmd.flag_code = rpn_pkg::ERR_NONE;
        in_stall      = (state_reg != rpn_pkg::ST_IDLE);
        unique case (state_reg)
            rpn_pkg::ST_IDLE:
            begin
                cmd.capture = in_valid;
            end
            rpn_pkg::ST_DECODE:
            begin
                if (!sts.err_set)
                begin
                    priority if (sts.is_digit)
                    begin
                        if (sts.full)
                        begin
                            cmd.flag_en   = 1'b1;
                            cmd.flag_code = rpn_pkg::ERR_OVERFLOW;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    else if (sts.is_op)
                    begin
                        priority if (sts.lt2)
                        begin
                            cmd.flag_en   = 1'b1;
                            cmd.flag_code = rpn_pkg::ERR_UNDERFLOW;
                        end
                        else if (sts.is_div && sts.newer_zero)
                        begin
                            cmd.flag_en   = 1'b1;
                            cmd.flag_code = rpn_pkg::ERR_DIVZERO;
                        end
                        else
                        begin
                            cmd.rd_issue = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.push = 1'b0;
                    end
                end
            end
            rpn_pkg::ST_READ:
            begin
                cmd.div_start = sts.is_div;
                cmd.alu_load  = !sts.is_div;
            end
            rpn_pkg::ST_DIV:
            begin
                cmd.div_load = sts.div_done;
            end
            rpn_pkg::ST_WB:
            begin
                cmd.pop = 1'b1;
            end
            rpn_pkg::ST_FINISH:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/rpn_stack_evaluator.sv =====
// Reverse Polish evaluator on a bounded stack of signed 32-bit values.
// Input channel: token and end_of_expr, taken when in_valid is high and
// in_stall is low. Digits push, + - * / combine the two top values, other
// characters only report. Output channel: top_value, error_code and last,
// taken when out_valid is high and out_stall is low; one result per item.
// One item is worked on at a time. A digit, an ignored character or a flagged
// item passes DECODE and FINISH; a valid + - * passes DECODE, READ, WB and
// FINISH, and / adds DIV, where the divider makes one quotient bit per cycle.
// The next item is accepted once the controller is back in IDLE. The stack
// keeps its top in a register and the rest in a memory with one write port
// and one registered read port, so an operator reads the older operand in
// READ. The result sits in an output register, so the next item is accepted
// while it waits; a stalled receiver holds the block in its final state
// until the register is free. Reset clears the stack count, the sticky
// error, the output valid flag and the controller state; stack contents need no clearing.
module rpn_stack_evaluator
#(
    parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rpn_pkg::TOKEN_W-1:0]        token,
    input  logic                               end_of_expr,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [rpn_pkg::DATA_W-1:0]  top_value,
    output logic [rpn_pkg::ERR_W-1:0]          error_code,
    output logic                               last
);

    rpn_pkg::cmd_t cmd;
    rpn_pkg::sts_t sts;

    rpn_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    rpn_dp
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .token       (token),
        .end_of_expr (end_of_expr),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .top_value   (top_value),
        .error_code  (error_code),
        .last        (last)
    );

endmodule
